// ----- hdl/cil_pkg.sv -----
package cil_pkg;

	// Curve store geometry.
	localparam int MAX_SAMPLES = 256;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

	// Field widths.
	localparam int DATA_W   = 32;
	localparam int INDEX_W  = 8;
	localparam int COUNT_W  = 9;
	localparam int FRAC_W   = 16;
	localparam int WEIGHT_W = FRAC_W + 1;

	// One store entry holds the value in the upper half and the time in the lower half.
	localparam int ENTRY_W = 2 * DATA_W;

	// Configuration port.
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	// Item kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Weight of exactly 1.0 in Q1.16.
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;

	typedef logic [ADDR_W-1:0] addr_t;

endpackage

// ----- hdl/cil_ram.sv -----
module cil_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/cil_div.sv -----
module cil_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cil_pkg::DATA_W-1:0]  dividend,
	input  logic [cil_pkg::DATA_W-1:0]  divisor,
	output logic                        done,
	output logic [cil_pkg::FRAC_W-1:0]  quotient
);

	import cil_pkg::*;

	localparam int STEP_W = $clog2(FRAC_W + 1);

	// Restoring division, one quotient bit per cycle. The dividend is known to be
	// below the divisor, so the quotient of (dividend << FRAC_W) fits FRAC_W bits.
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] div_q;
	logic [FRAC_W-1:0] quot_q;
	logic [STEP_W-1:0] steps_q;
	logic              run_q;
	logic              done_q;
	logic [DATA_W:0]   shifted;
	logic              fits;

	assign shifted = {rem_q, 1'b0};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q   <= 1'b1;
				steps_q <= STEP_W'(FRAC_W);
			end else if (run_q) begin
				steps_q <= steps_q - STEP_W'(1);
				if (steps_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			div_q  <= divisor;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= fits ? DATA_W'(shifted - {1'b0, div_q}) : DATA_W'(shifted);
			quot_q <= {quot_q[FRAC_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ----- hdl/curve_inverse_lookup.sv -----
// Channel   | Direction | Signals                                           | Handshake
// ----------+-----------+---------------------------------------------------+-------------------------
// item in   | in        | kind, sample_index, sample_value, sample_time,    | start high, busy low
//           |           | query_value                                       |
// result    | out       | result_time, too_few_samples                      | done, one cycle
// config    | in/out    | psel, penable, pwrite, paddr, pwdata, prdata      | APB, pready always high
//
// A load item is written into the curve store at the accepting edge; busy never rises for it.
// A query item keeps busy high while the sequencer checks the first and last samples and, unless
// one answers it, searches the store through its single read port and interpolates.
// A query with fewer than two samples answers in the next cycle without raising busy.
// Reset clears the sequencer and the sample count; the curve store is not cleared.
// The receiver cannot stall: each result is on the ports for the one cycle that done is high.
module curve_inverse_lookup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [cil_pkg::INDEX_W-1:0]   sample_index,
	input  logic signed [cil_pkg::DATA_W-1:0] sample_value,
	input  logic signed [cil_pkg::DATA_W-1:0] sample_time,
	input  logic signed [cil_pkg::DATA_W-1:0] query_value,
	output logic                          done,
	output logic signed [cil_pkg::DATA_W-1:0] result_time,
	output logic                          too_few_samples,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cil_pkg::PADDR_W-1:0]   paddr,
	input  logic [cil_pkg::PDATA_W-1:0]   pwdata,
	output logic [cil_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	import cil_pkg::*;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_RD_FIRST  = 4'd1;
	localparam logic [3:0] ST_CHK_FIRST = 4'd2;
	localparam logic [3:0] ST_RD_LAST   = 4'd3;
	localparam logic [3:0] ST_CHK_LAST  = 4'd4;
	localparam logic [3:0] ST_SEARCH    = 4'd5;
	localparam logic [3:0] ST_PROBE     = 4'd6;
	localparam logic [3:0] ST_RD_NEXT   = 4'd7;
	localparam logic [3:0] ST_SETUP     = 4'd8;
	localparam logic [3:0] ST_DIV       = 4'd9;
	localparam logic [3:0] ST_MUL       = 4'd10;
	localparam logic [3:0] ST_ADD       = 4'd11;

	// Configuration register. The port holds a single register, so every address
	// within its two address bits selects it.
	logic [COUNT_W-1:0] sample_count_q;
	logic               cfg_write;

	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign prdata    = PDATA_W'(sample_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
		end else if (cfg_write) begin
			sample_count_q <= COUNT_W'(pwdata);
		end
	end

	// Effective sample count, limited to the store depth.
	logic [CNT_W-1:0] n_eff;
	logic             few;

	assign n_eff = (32'(sample_count_q) > 32'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
		: CNT_W'(sample_count_q);
	assign few   = n_eff < CNT_W'(2);

	// Item acceptance.
	logic accept;
	logic load_wr;

	assign accept  = start && !busy;
	assign load_wr = accept && (kind == KIND_LOAD) && (32'(sample_index) < 32'(MAX_SAMPLES));

	// Sequencer registers.
	logic [3:0]               state_q;
	logic signed [DATA_W-1:0] q_q;
	addr_t                    last_q;
	addr_t                    next_q;
	addr_t                    cnt_q;
	addr_t                    step_q;
	addr_t                    mid_q;
	logic signed [DATA_W-1:0] tp_q;
	logic signed [DATA_W-1:0] vp_q;
	logic signed [DATA_W:0]   tdiff_q;
	logic [WEIGHT_W-1:0]      w_q;
	logic signed [DATA_W+WEIGHT_W:0] prod_q;
	logic                     done_q;
	logic signed [DATA_W-1:0] result_q;
	logic                     few_q;

	// Curve store: one entry carries the value and the time of a sample.
	addr_t               raddr;
	logic [ENTRY_W-1:0]  rdata;
	logic signed [DATA_W-1:0] rd_value;
	logic signed [DATA_W-1:0] rd_time;

	assign rd_value = rdata[ENTRY_W-1:DATA_W];
	assign rd_time  = rdata[DATA_W-1:0];

	cil_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (load_wr),
		.waddr(ADDR_W'(sample_index)),
		.wdata({sample_value, sample_time}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Store address follows the state; the store registers its read data, which arrives in the next cycle.
	always_comb begin
		unique case (state_q)
			ST_RD_FIRST: raddr = '0;
			ST_RD_LAST:  raddr = last_q;
			ST_SEARCH:   raddr = (cnt_q == '0) ? next_q - ADDR_W'(1)
				: next_q + (cnt_q >> 1);
			ST_RD_NEXT:  raddr = next_q;
			default:     raddr = '0;
		endcase
	end

	// Interpolation setup from the bracketing pair.
	logic signed [DATA_W:0] diff;
	logic signed [DATA_W:0] num;
	logic                   w_zero;
	logic                   w_full;
	logic                   div_start;
	logic                   div_done;
	logic [FRAC_W-1:0]      div_quot;

	assign diff      = {rd_value[DATA_W-1], rd_value} - {vp_q[DATA_W-1], vp_q};
	assign num       = {q_q[DATA_W-1], q_q} - {vp_q[DATA_W-1], vp_q};
	assign w_zero    = (diff <= 0) || (num <= 0);
	assign w_full    = num >= diff;
	assign div_start = (state_q == ST_SETUP) && !w_zero && !w_full;

	cil_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(num[DATA_W-1:0]),
		.divisor (diff[DATA_W-1:0]),
		.done    (div_done),
		.quotient(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && kind == KIND_QUERY) begin
						if (few) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_RD_FIRST;
						end
					end
				end
				ST_RD_FIRST: state_q <= ST_CHK_FIRST;
				ST_CHK_FIRST: begin
					if (q_q <= rd_value) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RD_LAST;
					end
				end
				ST_RD_LAST: state_q <= ST_CHK_LAST;
				ST_CHK_LAST: begin
					if (q_q >= rd_value) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH:  state_q <= (cnt_q == '0) ? ST_RD_NEXT : ST_PROBE;
				ST_PROBE:   state_q <= ST_SEARCH;
				ST_RD_NEXT: state_q <= ST_SETUP;
				ST_SETUP:   state_q <= (w_zero || w_full) ? ST_MUL : ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				q_q      <= query_value;
				last_q   <= ADDR_W'(n_eff - CNT_W'(1));
				result_q <= '0;
				few_q    <= 1'b1;
			end
			ST_CHK_FIRST: begin
				result_q <= rd_time;
				few_q    <= 1'b0;
			end
			ST_CHK_LAST: begin
				result_q <= rd_time;
				next_q   <= ADDR_W'(1);
				cnt_q    <= last_q - ADDR_W'(1);
			end
			ST_SEARCH: begin
				step_q <= cnt_q >> 1;
				mid_q  <= next_q + (cnt_q >> 1);
			end
			ST_PROBE: begin
				// Lower-bound step: move past the probe when the query lies above it.
				if (q_q > rd_value) begin
					next_q <= mid_q + ADDR_W'(1);
					cnt_q  <= cnt_q - step_q - ADDR_W'(1);
				end else begin
					cnt_q <= step_q;
				end
			end
			ST_RD_NEXT: begin
				vp_q <= rd_value;
				tp_q <= rd_time;
			end
			ST_SETUP: begin
				tdiff_q <= {rd_time[DATA_W-1], rd_time} - {tp_q[DATA_W-1], tp_q};
				w_q     <= w_zero ? '0 : WEIGHT_ONE;
			end
			ST_DIV: begin
				if (div_done) begin
					w_q <= WEIGHT_W'(div_quot);
				end
			end
			ST_MUL: begin
				prod_q <= tdiff_q * $signed({1'b0, w_q});
			end
			ST_ADD: begin
				// Arithmetic shift of the product floors toward minus infinity.
				result_q <= tp_q + prod_q[DATA_W+FRAC_W-1:FRAC_W];
			end
			default: begin
			end
		endcase
	end

	assign busy            = state_q != ST_IDLE;
	assign done            = done_q;
	assign result_time     = result_q;
	assign too_few_samples = few_q;

endmodule

// ----- tb/tb_curve_inverse_lookup.sv -----
module tb_curve_inverse_lookup;
	timeunit 1ns;
	timeprecision 1ps;

	import cil_pkg::*;

	// The sample count register is the only register; every address selects it, and zero is used here.
	localparam logic [PADDR_W-1:0] SAMPLE_COUNT_ADDR = '0;

	// Cycles allowed for the block to settle after the last result, with a wide
	// margin over the time a full-size query keeps busy high.
	localparam int SETTLE_CYCLES = 64;

	// One item as the sender presents it. The hold flag makes the driver wait
	// until every result already due has come back before it offers the item.
	typedef struct {
		logic                      kind;
		logic [INDEX_W-1:0]        idx;
		logic signed [DATA_W-1:0]  sval;
		logic signed [DATA_W-1:0]  stim;
		logic signed [DATA_W-1:0]  qval;
		bit                        hold;
	} lookup_item_t;

	// One answer the block owes for an accepted query.
	typedef struct {
		logic signed [DATA_W-1:0]  t_q16;
		logic                      few;
	} lookup_answer_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic                      kind = KIND_LOAD;
	logic [INDEX_W-1:0]        sample_index = '0;
	logic signed [DATA_W-1:0]  sample_value = '0;
	logic signed [DATA_W-1:0]  sample_time = '0;
	logic signed [DATA_W-1:0]  query_value = '0;
	logic                      done;
	logic signed [DATA_W-1:0]  result_time;
	logic                      too_few_samples;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [PADDR_W-1:0]        paddr = '0;
	logic [PDATA_W-1:0]        pwdata = '0;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;

	curve_inverse_lookup u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.sample_index    (sample_index),
		.sample_value    (sample_value),
		.sample_time     (sample_time),
		.query_value     (query_value),
		.done            (done),
		.result_time     (result_time),
		.too_few_samples (too_few_samples),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always #10 clk = ~clk;

	// Items waiting to be offered, the item currently on the ports, and the
	// answers owed by the block in the order the queries were accepted.
	lookup_item_t    pending_items[$];
	lookup_item_t    on_port;
	lookup_answer_t  answers_due[$];

	// The predictor's own copy of the curve and of the sample count register.
	// Entries are only ever read after the stimulus has written them.
	logic signed [DATA_W-1:0]  curve_val [0:MAX_SAMPLES-1];
	logic signed [DATA_W-1:0]  curve_tim [0:MAX_SAMPLES-1];
	int unsigned               active_count = 0;

	// The stimulus generator's view of the curve values, used to aim queries
	// at samples and at the gaps between them.
	logic signed [DATA_W-1:0]  plan_val [0:MAX_SAMPLES-1];

	int  idle_pct = 0;
	int  planned = 0;
	int  errors = 0;

	// Inverse lookup of a curve with n >= 2 samples in use. A lower-bound binary
	// search over 1..n-2 picks the upper sample of the bracketing pair. The Q1.16
	// weight is the floored quotient, clipped to 0..1.0, and the weighted time
	// step is floored toward minus infinity by the arithmetic shift.
	function automatic logic signed [DATA_W-1:0] interp_time(
			input logic signed [DATA_W-1:0] q, input int unsigned n);
		int unsigned  last;
		int unsigned  nxt;
		int unsigned  span;
		int unsigned  half;
		int unsigned  mid;
		longint       vp, vn, tp, tn, diff, num, w;

		last = n - 1;
		if (q <= curve_val[0])
			return curve_tim[0];
		if (q >= curve_val[last])
			return curve_tim[last];
		nxt = 1;
		span = last - nxt;
		while (span > 0) begin
			half = span / 2;
			mid = nxt + half;
			if (q > curve_val[mid]) begin
				nxt = mid + 1;
				span -= half + 1;
			end else begin
				span = half;
			end
		end
		vp = curve_val[nxt - 1];
		vn = curve_val[nxt];
		tp = curve_tim[nxt - 1];
		tn = curve_tim[nxt];
		diff = vn - vp;
		num = q - vp;
		if (diff <= 0 || num <= 0)
			w = 0;
		else if (num >= diff)
			w = 64'sd65536;
		else
			w = (num <<< FRAC_W) / diff;
		return DATA_W'(tp + (((tn - tp) * w) >>> FRAC_W));
	endfunction

	// Applies one accepted item to the predictor: a load updates the curve copy,
	// a query adds the answer the block must give.
	function automatic void track_item(input lookup_item_t it);
		lookup_answer_t  ans;
		int unsigned     n;

		if (it.kind == KIND_LOAD) begin
			curve_val[it.idx] = it.sval;
			curve_tim[it.idx] = it.stim;
		end else begin
			n = (active_count > MAX_SAMPLES) ? MAX_SAMPLES : active_count;
			if (n < 2) begin
				ans.t_q16 = '0;
				ans.few = 1'b1;
			end else begin
				ans.t_q16 = interp_time(it.qval, n);
				ans.few = 1'b0;
			end
			answers_due.push_back(ans);
		end
	endfunction

	// Queue builders. The fields a kind does not use are filled with random
	// noise, which the block must ignore.
	function automatic void push_load(input logic [INDEX_W-1:0] idx,
			input logic signed [DATA_W-1:0] v, input logic signed [DATA_W-1:0] t);
		lookup_item_t  it;

		it.kind = KIND_LOAD;
		it.idx = idx;
		it.sval = v;
		it.stim = t;
		it.qval = $urandom;
		it.hold = 1'b0;
		plan_val[idx] = v;
		pending_items.push_back(it);
		planned++;
	endfunction

	function automatic void push_query(input logic signed [DATA_W-1:0] q, input bit hold);
		lookup_item_t  it;

		it.kind = KIND_QUERY;
		it.idx = INDEX_W'($urandom);
		it.sval = $urandom;
		it.stim = $urandom;
		it.qval = q;
		it.hold = hold;
		pending_items.push_back(it);
		planned++;
	endfunction

	// Returns once every queued item has been taken and every answer checked.
	// Sampling at the falling edge keeps this clear of the rising-edge updates.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || start || answers_due.size() != 0);
	endtask

	// Writes the sample count while the block is idle and reads it back. The
	// read setup cycle follows the write access cycle with psel held high.
	task automatic write_count(input int unsigned val);
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SAMPLE_COUNT_ADDR;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		active_count = val & 32'h1FF;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== (val & 32'h1FF)) begin
			errors++;
			$display("%0t: sample_count readback expected %h got %h",
				$time, val & 32'h1FF, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Driver. An item is taken at a rising edge where start is high and busy is
	// low; the predictor sees it at that same edge. While busy is high the item
	// stays on the ports. Otherwise the next item goes out unless the sender
	// idles this cycle or the item has to wait for all answers to come back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				track_item(on_port);
			if (start && busy) begin
				// The item on the ports has not been taken yet.
			end else if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
					!(pending_items[0].hold && (answers_due.size() != 0 || start))) begin
				on_port = pending_items.pop_front();
				start <= 1'b1;
				kind <= on_port.kind;
				sample_index <= on_port.idx;
				sample_value <= on_port.sval;
				sample_time <= on_port.stim;
				query_value <= on_port.qval;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor. A result is valid for the single cycle that done is high and is
	// taken at the rising edge that ends that cycle.
	always @(posedge clk) begin : result_check
		lookup_answer_t  want;

		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none got time %h flag %b",
					$time, result_time, too_few_samples);
			end else begin
				want = answers_due.pop_front();
				if (result_time !== want.t_q16) begin
					errors++;
					$display("%0t: result_time expected %h got %h",
						$time, want.t_q16, result_time);
				end
				if (too_few_samples !== want.few) begin
					errors++;
					$display("%0t: too_few_samples expected %b got %b",
						$time, want.few, too_few_samples);
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int unsigned               n;
		int                        nl;
		int                        k;
		int                        shape;
		int                        pick;
		int                        i;
		longint                    acc;
		longint                    lo;
		longint                    hi;
		logic signed [DATA_W-1:0]  q;
		logic signed [DATA_W-1:0]  v;
		lookup_answer_t            missing;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. With no samples in use every query reports too few
		// samples, whatever its value.
		write_count(0);
		push_query(32'sh8000_0000, 1'b0);

		// A curve that spans the full time range, with a plateau in
		// the middle and the largest value at the top.
		push_load(INDEX_W'(0), 32'shC000_0000, 32'sh7FFF_FFFF);
		push_load(INDEX_W'(1), 32'shFFFF_0000, 32'sh8000_0000);
		push_load(INDEX_W'(2), 32'sh0002_0000, 32'sh0001_8000);
		push_load(INDEX_W'(3), 32'sh0002_0000, 32'sh1234_5678);
		push_load(INDEX_W'(4), 32'sh7FFF_FFFF, 32'shFFFF_FFFF);

		// A single sample is still too few.
		write_count(1);
		push_query(32'sh7FFF_FFFF, 1'b0);

		// Five samples: below the first value, on the first value, between the
		// first two (a large falling time step, so the floor acts on negative
		// products), exactly on an inner sample (weight of one), on the plateau,
		// on the last value, and inside an ordinary gap.
		write_count(5);
		push_query(32'sh8000_0000, 1'b0);
		push_query(32'shC000_0000, 1'b0);
		push_query(32'shE000_0000, 1'b0);
		push_query(32'shFFFF_0000, 1'b0);
		push_query(32'sh0002_0000, 1'b0);
		push_query(32'sh7FFF_FFFF, 1'b0);
		push_query(32'sh0001_0000, 1'b0);

		// Four samples: the top of the curve is now the plateau, so values above
		// it return the last time.
		write_count(4);
		push_query(32'sh7FFF_FFFF, 1'b1);
		push_query(32'sh0002_0001, 1'b0);
		push_query(32'shFFFF_8000, 1'b0);

		// Move the first sample to the smallest value and query at and just
		// above it.
		push_load(INDEX_W'(0), 32'sh8000_0000, 32'sh0000_0000);
		push_query(32'sh8000_0000, 1'b0);
		push_query(32'sh8000_0001, 1'b0);

		// Random part, one sample count per phase. The first phase fills the
		// whole store and the second uses the largest count the register holds,
		// which the block clamps to the store size; from then on every entry
		// has been written, so counts above the store size are safe at any time.
		for (int p = 1; planned < 550; p++) begin
			if (p == 1) begin
				n = MAX_SAMPLES;
			end else if (p == 2) begin
				n = 511;
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					n = 0;
				else if (pick == 1)
					n = 1;
				else if (pick == 2)
					n = $urandom_range(MAX_SAMPLES + 1, 511);
				else if (pick == 3)
					n = $urandom_range(13, 48);
				else
					n = $urandom_range(2, 12);
			end
			write_count(n);
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 74;
				default: idle_pct = 7;
			endcase
			nl = (n > MAX_SAMPLES) ? MAX_SAMPLES : n;

			// Load a fresh curve. Most curves are sorted, some with plateaus,
			// some starting at the smallest value; a few are scrambled.
			if (n >= 2 && n <= MAX_SAMPLES) begin
				shape = $urandom_range(0, 9);
				acc = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
				if (shape == 5)
					acc = -64'sd2147483648;
				for (i = 0; i < nl; i++) begin
					if (shape >= 8) begin
						v = $urandom;
					end else begin
						v = DATA_W'(acc);
						if (shape >= 6 && $urandom_range(0, 2) == 0)
							acc += 0;
						else
							acc += $urandom_range(1, (1 << 29) / nl);
					end
					push_load(INDEX_W'(i), v, $urandom);
				end
			end

			// Queries aimed at samples, gaps and the ends of the curve, mixed
			// with full-range values and with stray loads that disturb the curve.
			k = (nl >= MAX_SAMPLES) ? 40 : $urandom_range(8, 30);
			for (int j = 0; j < k; j++) begin
				if ($urandom_range(0, 7) == 0) begin
					push_load(INDEX_W'($urandom), $urandom, $urandom);
				end else begin
					pick = (nl >= 2) ? $urandom_range(0, 9) : 8;
					case (pick)
						0, 1, 2: begin
							q = plan_val[$urandom_range(0, nl - 1)];
						end
						3, 4, 5, 6: begin
							i = $urandom_range(0, nl - 2);
							lo = plan_val[i];
							hi = plan_val[i + 1];
							q = DATA_W'(lo + ((hi - lo) * longint'($urandom_range(0, 65535))) / 65536);
						end
						7: begin
							if ($urandom_range(0, 1) == 0)
								q = plan_val[0] - $urandom_range(1, 4096);
							else
								q = plan_val[nl - 1] + $urandom_range(1, 4096);
						end
						default: begin
							pick = $urandom_range(0, 5);
							if (pick == 0)
								q = 32'sh8000_0000;
							else if (pick == 1)
								q = 32'sh7FFF_FFFF;
							else
								q = $urandom;
						end
					endcase
					push_query(q, $urandom_range(0, 24) == 0);
				end
			end
		end

		// Let the driver hand over everything, then give the answers time to
		// arrive, with a bound in case some never do.
		do
			@(negedge clk);
		while (pending_items.size() != 0 || start);
		for (int c = 0; c < 5000 && answers_due.size() != 0; c++)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		while (answers_due.size() != 0) begin
			missing = answers_due.pop_front();
			errors++;
			$display("%0t: result expected time %h flag %b got none",
				$time, missing.t_q16, missing.few);
		end
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: a correct run takes well under a tenth of this.
	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
